// ===== hw/rtl/text_console_char_engine_unit_assert.svh =====
// Assertion shorthands for the console engine RTL.
// Each one samples on the rising edge of clk and is off while arst_n is low.
`ifndef TEXT_CONSOLE_CHAR_ENGINE_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_ENGINE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCCE_ASSERT_HOLDS(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCCE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/tcce_pkg.sv =====
`timescale 1ns / 1ps

package tcce_pkg;

	localparam int COLUMNS     = 80;
	localparam int ROWS        = 25;
	localparam int CELLS       = ROWS * COLUMNS;
	localparam int TAB_STOP    = 8;
	localparam int TAB_SHIFT   = $clog2(TAB_STOP);
	localparam int ADDR_W      = $clog2(CELLS);
	localparam int COL_W       = $clog2(COLUMNS + TAB_STOP);
	localparam int ROW_W       = $clog2(ROWS + 1);
	localparam int IDX_W       = 11;
	localparam int CHAR_W      = 8;
	localparam int CELL_W      = 16;
	localparam int COLOR_W     = 4;
	localparam int CFG_IDX_W   = 1;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CELL_W-1:0]  BLANK_CELL = 16'h0F20;
	localparam logic [COLOR_W-1:0] BG_RESET   = 4'h0;
	localparam logic [COLOR_W-1:0] FG_RESET   = 4'hF;

	localparam logic [CHAR_W-1:0] CH_BS       = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF       = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'h20;
	localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'h7F;

	localparam logic OP_PUT  = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FOREGROUND = 1'd1;

	typedef struct packed {
		logic              op;
		logic [CHAR_W-1:0] char_code;
		logic [IDX_W-1:0]  cell_index;
	} item_t;

	typedef struct packed {
		logic [IDX_W-1:0]  cursor_position;
		logic [CELL_W-1:0] cell_data;
		logic              scrolled;
	} result_t;

	// One classified item on its way from the front end to the screen memory.
	typedef struct packed {
		logic              is_read;
		logic              in_range;
		logic              do_write;
		logic              do_scroll;
		logic [ADDR_W-1:0] addr;
		logic [CELL_W-1:0] wdata;
		logic [ADDR_W-1:0] blank_base;
		logic [IDX_W-1:0]  cursor_position;
	} cmd_t;

	typedef struct packed {
		logic clearing;
	} back_status_t;

endpackage

// ===== hw/rtl/text_console_char_engine_unit.sv =====
`timescale 1ns / 1ps

// Text console engine: an 80x25 screen of 16-bit cells (attribute high, character low) and a
// cursor. A put transaction interprets one byte (backspace, tab, CR, LF, printable 0x20..0x7F),
// a read transaction returns one cell, and every result carries the cursor position. The front
// end classifies a transaction and updates the cursor in the cycle it is accepted and hands it
// to a two-entry queue; the back end owns the dual-port screen memory. In the back end a put
// is handled in the idle state and a read goes through a read state (registered memory read). A
// put that scrolls also blanks the new bottom row one cell per cycle; the scroll itself is a
// move of the ring base, not a copy. After reset a pass clears all 2000 cells to 0x0F20, during
// which no transaction is accepted on the item channel; color writes are taken throughout.
module text_console_char_engine_unit import tcce_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COLOR_W-1:0]   cfg_data,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  item_t                item,
	output logic                 result_valid,
	input  logic                 result_ready,
	output result_t              result
);

	logic         queue_full;
	logic         push_valid;
	cmd_t         push_cmd;
	logic         q_valid;
	logic         q_pop;
	cmd_t         q_cmd;
	back_status_t back_status;

	tcce_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.back_status (back_status),
		.queue_full  (queue_full),
		.push_valid  (push_valid),
		.push_cmd    (push_cmd)
	);

	tcce_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push_valid),
		.push_cmd (push_cmd),
		.full     (queue_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.pop_cmd  (q_cmd)
	);

	tcce_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_cmd        (q_cmd),
		.q_pop        (q_pop),
		.status       (back_status),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// ===== hw/rtl/tcce_front.sv =====
`timescale 1ns / 1ps

module tcce_front import tcce_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COLOR_W-1:0]   cfg_data,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  item_t                item,
	input  back_status_t         back_status,
	input  logic                 queue_full,
	output logic                 push_valid,
	output cmd_t                 push_cmd
);

	localparam logic [ADDR_W:0] CELLS_X   = (ADDR_W+1)'(CELLS);
	localparam logic [ADDR_W:0] COLUMNS_X = (ADDR_W+1)'(COLUMNS);

	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic [ADDR_W-1:0]  top_base_q;
	logic [COLOR_W-1:0] bg_q;
	logic [COLOR_W-1:0] fg_q;

	logic               accept;
	logic               is_read;
	logic               is_print;
	logic               scroll;
	logic [COL_W-1:0]   col_n;
	logic [ROW_W-1:0]   row_n;
	logic [COL_W-1:0]   tab_sum;
	logic [COL_W-1:0]   tab_col;
	logic [ADDR_W-1:0]  cur_lin;
	logic [ADDR_W-1:0]  new_lin;
	logic [ADDR_W:0]    top_sum;
	logic [ADDR_W-1:0]  top_base_n;

	// The screen is a ring of rows: logical row 0 starts at top_base_q.
	function automatic logic [ADDR_W-1:0] to_phys(input logic [ADDR_W-1:0] lin,
		input logic [ADDR_W-1:0] base);
		logic [ADDR_W:0] sum;
		sum = {1'b0, lin} + {1'b0, base};
		if (sum >= CELLS_X) begin
			sum = sum - CELLS_X;
		end
		return sum[ADDR_W-1:0];
	endfunction

	assign cfg_ready  = 1'b1;
	assign item_ready = !queue_full && !back_status.clearing;
	assign accept     = item_valid && item_ready;
	assign push_valid = accept;
	assign is_read    = (item.op == OP_READ);

	assign tab_sum = col_q + COL_W'(TAB_STOP);
	assign tab_col = {tab_sum[COL_W-1:TAB_SHIFT], {TAB_SHIFT{1'b0}}};

	always_comb begin
		col_n    = col_q;
		row_n    = row_q;
		is_print = 1'b0;
		case (item.char_code) inside
			CH_BS: begin
				if (col_q != '0) begin
					col_n = col_q - 1'b1;
				end
			end
			CH_TAB: begin
				col_n = tab_col;
			end
			CH_CR: begin
				col_n = '0;
			end
			CH_LF: begin
				col_n = '0;
				row_n = row_q + 1'b1;
			end
			[CH_PRINT_LO:CH_PRINT_HI]: begin
				is_print = 1'b1;
				col_n    = col_q + 1'b1;
			end
			default: begin
			end
		endcase
		if (col_n >= COL_W'(COLUMNS)) begin
			col_n = '0;
			row_n = row_n + 1'b1;
		end
		scroll = (row_n == ROW_W'(ROWS));
		if (scroll) begin
			row_n = ROW_W'(ROWS - 1);
		end
	end

	assign cur_lin = ADDR_W'(row_q * COLUMNS) + ADDR_W'(col_q);
	assign new_lin = ADDR_W'(row_n * COLUMNS) + ADDR_W'(col_n);

	assign top_sum    = {1'b0, top_base_q} + COLUMNS_X;
	assign top_base_n = (top_sum == CELLS_X) ? '0 : top_sum[ADDR_W-1:0];

	always_comb begin
		push_cmd.is_read    = is_read;
		push_cmd.in_range   = (32'(item.cell_index) < CELLS);
		push_cmd.do_write   = !is_read && is_print;
		push_cmd.do_scroll  = !is_read && scroll;
		push_cmd.addr       = is_read ? to_phys(ADDR_W'(item.cell_index), top_base_q)
		                              : to_phys(cur_lin, top_base_q);
		push_cmd.wdata      = {bg_q, fg_q, item.char_code};
		// The row that scrolls off the top is reused as the new bottom row.
		push_cmd.blank_base = top_base_q;
		push_cmd.cursor_position = is_read ? IDX_W'(cur_lin) : IDX_W'(new_lin);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			top_base_q <= '0;
		end else if (accept && !is_read) begin
			col_q <= col_n;
			row_q <= row_n;
			if (scroll) begin
				top_base_q <= top_base_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_q <= BG_RESET;
			fg_q <= FG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_BACKGROUND: bg_q <= cfg_data;
				CFG_FOREGROUND: fg_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/tcce_queue.sv =====
`timescale 1ns / 1ps

module tcce_queue import tcce_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic valid,
	output cmd_t pop_cmd
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign valid   = (count_q != '0);
	assign pop_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/tcce_back.sv =====
`timescale 1ns / 1ps
`include "text_console_char_engine_unit_assert.svh"

module tcce_back import tcce_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_valid,
	input  cmd_t         q_cmd,
	output logic         q_pop,
	output back_status_t status,
	output logic         result_valid,
	input  logic         result_ready,
	output result_t      result
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_READ  = 2'd2;
	localparam logic [1:0] ST_BLANK = 2'd3;

	logic [CELL_W-1:0] mem [CELLS];

	logic [1:0]        state_q;
	logic [ADDR_W-1:0] cnt_q;
	cmd_t              cmd_q;
	logic [CELL_W-1:0] rd_data_q;
	logic              result_valid_q;
	result_t           result_q;

	logic              slot_free;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [CELL_W-1:0] mem_wdata;
	logic [ADDR_W-1:0] mem_raddr;
	logic              result_load;
	result_t           result_d;
	logic              blank_last;
	logic              clear_last;

	assign slot_free    = !result_valid_q || result_ready;
	assign q_pop        = (state_q == ST_IDLE) && q_valid && slot_free;
	assign mem_raddr    = q_cmd.addr;
	assign blank_last   = (cnt_q == ADDR_W'(COLUMNS - 1));
	assign clear_last   = (cnt_q == ADDR_W'(CELLS - 1));
	assign status.clearing = (state_q == ST_CLEAR);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_comb begin
		mem_we      = 1'b0;
		mem_waddr   = cnt_q;
		mem_wdata   = BLANK_CELL;
		result_load = 1'b0;
		result_d    = '{cursor_position: cmd_q.cursor_position, cell_data: '0, scrolled: 1'b0};
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_IDLE: begin
				if (q_pop && q_cmd.do_write) begin
					mem_we    = 1'b1;
					mem_waddr = q_cmd.addr;
					mem_wdata = q_cmd.wdata;
				end
				if (q_pop && !q_cmd.is_read && !q_cmd.do_scroll) begin
					result_load = 1'b1;
					result_d.cursor_position = q_cmd.cursor_position;
				end
			end
			ST_READ: begin
				result_load = 1'b1;
				result_d.cell_data = cmd_q.in_range ? rd_data_q : '0;
			end
			ST_BLANK: begin
				mem_we    = 1'b1;
				mem_waddr = cmd_q.blank_base + cnt_q;
				if (blank_last) begin
					result_load       = 1'b1;
					result_d.scrolled = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_cmd;
		end
		if (result_load) begin
			result_q <= result_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			cnt_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (result_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (clear_last) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (q_pop && q_cmd.is_read) begin
						state_q <= ST_READ;
					end else if (q_pop && q_cmd.do_scroll) begin
						cnt_q   <= '0;
						state_q <= ST_BLANK;
					end
				end
				ST_READ: begin
					state_q <= ST_IDLE;
				end
				ST_BLANK: begin
					if (blank_last) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`TCCE_ASSERT_HOLDS(a_blank_in_row, state_q == ST_BLANK, cnt_q < ADDR_W'(COLUMNS), "blank count ran past the row")
	`TCCE_ASSERT_HOLDS(a_load_slot_free, result_load, slot_free, "result overwritten before it was taken")
	`TCCE_ASSERT_NEXT(a_clear_once, state_q != ST_CLEAR, state_q != ST_CLEAR, "clearing pass restarted")
	`TCCE_ASSERT_NEXT(a_read_one_cycle, state_q == ST_READ, state_q == ST_IDLE, "read did not finish in one cycle")
	`TCCE_ASSERT_HOLDS(a_scroll_from_blank, result_load && result_d.scrolled, state_q == ST_BLANK, "scroll reported without a row blank")

endmodule
